/* hdl/radial_falloff_lookup_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the radial falloff lookup unit
// Clocked on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RADIAL_FALLOFF_LOOKUP_UNIT_MACROS_SVH
`define RADIAL_FALLOFF_LOOKUP_UNIT_MACROS_SVH

// Condition that holds at every edge.
`define RFL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define RFL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rfl_pkg.sv */
// ----------------------------------------------------------------------------
// rfl_pkg
// Widths, codes and shared types of the radial falloff lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rfl_pkg;

  // Field widths
  localparam int unsigned COORD_W  = 13;
  localparam int unsigned EIDX_W   = 10;
  localparam int unsigned WEIGHT_W = 29;
  localparam int unsigned RIDX_W   = 10;
  localparam int unsigned LAYER_W  = 11;
  localparam int unsigned METRIC_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Internal widths: |2c - size + 1| stays below 2^14, the sum of squares
  // below 2^28, so four times it fits 32 bits and its root 16 bits.
  localparam int unsigned TX_W   = 14;
  localparam int unsigned SQ_W   = 2 * TX_W;
  localparam int unsigned ROOT_W = 16;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned IDX_W  = 14;

  // Defaults
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned MAX_LAYER   = 1024;
  localparam int unsigned FIFO_DEPTH  = 32;

  localparam logic [WEIGHT_W-1:0] UNITY_WEIGHT = 29'h1000_0000;
  localparam logic [LAYER_W-1:0]  LAYER_RESET  = 11'd1024;

  // Metric codes
  localparam logic [METRIC_W-1:0] METRIC_R = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_S = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_D = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Item data riding alongside the root chain
  typedef struct packed {
    logic                op;
    logic                use_sqrt;
    logic [IDX_W-1:0]    idx_rs;
    logic [EIDX_W-1:0]   eidx;
    logic [WEIGHT_W-1:0] evalue;
  } side_t;

endpackage

`default_nettype wire

/* hdl/radial_falloff_lookup_unit.sv */
// ----------------------------------------------------------------------------
// radial_falloff_lookup_unit
// Coordinate to falloff weight lookup with R, S ring and Euclidean metrics.
// ----------------------------------------------------------------------------
// Takes one item per clock while it has credit and returns exactly one result
// item per input item, in order. The accept edge registers the centered,
// folded doubled coordinate. After it, the squares are registered, then their
// sum, and sixteen cells of the square root chain each settle one root bit.
// The index stage forms and clamps the table index while the table is read,
// and the result is pushed into the result queue. The pipeline depth is set
// by the root chain; the falloff table has one write and one read port and
// serves one item per cycle. Write items take the same path, so a lookup
// right after a write to the same entry sees the new value. A 32-entry result
// queue with credit counting decouples the output: the input keeps taking
// items while results wait, and stops only when 32 items are in flight or
// queued. The table has no reset and no clearing pass; reading an entry never
// written returns whatever the RAM holds. The user must write configuration
// registers only while the unit is empty; the unit does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radial_falloff_lookup_unit_macros.svh"

module radial_falloff_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = rfl_pkg::TABLE_DEPTH,
  parameter int unsigned MAX_LAYER   = rfl_pkg::MAX_LAYER
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [rfl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rfl_pkg::LAYER_W-1:0]   cfg_data_i,
  // Input items
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [12:0] coord_x, [25:13] coord_y, [35:26] entry_index,
  // [64:36] entry_value, [71:65] zero
  input  wire logic [71:0]                   s_axis_tdata_i,
  // [0] op
  input  wire logic                          s_axis_tuser_i,
  // Result items
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [28:0] weight, [38:29] radius_index, [39] clipped
  output logic      [39:0]                   m_axis_tdata_o
);

  localparam int unsigned COORD_W  = rfl_pkg::COORD_W;
  localparam int unsigned WEIGHT_W = rfl_pkg::WEIGHT_W;
  localparam int unsigned RIDX_W   = rfl_pkg::RIDX_W;
  localparam int unsigned LAYER_W  = rfl_pkg::LAYER_W;
  localparam int unsigned TX_W     = rfl_pkg::TX_W;
  localparam int unsigned SQ_W     = rfl_pkg::SQ_W;
  localparam int unsigned ROOT_W   = rfl_pkg::ROOT_W;
  localparam int unsigned RAD_W    = rfl_pkg::RAD_W;
  localparam int unsigned IDX_W    = rfl_pkg::IDX_W;
  localparam int unsigned FIFO_D   = rfl_pkg::FIFO_DEPTH;
  localparam int unsigned RES_W    = WEIGHT_W + RIDX_W + 1;
  localparam int unsigned CR_W     = $clog2(FIFO_D + 1);
  localparam int unsigned ADDR_W   = $clog2(TABLE_DEPTH);
  // Wide enough for the index, the table depth itself and the entry index
  localparam int unsigned CMP_W    = (ADDR_W > IDX_W ? ADDR_W : IDX_W) + 2;
  localparam int unsigned LCMP_W   = 14;
  localparam int unsigned DIFF_W   = 16;

  localparam logic [CMP_W-1:0]   DEPTH_C   = CMP_W'(TABLE_DEPTH);
  localparam logic [CMP_W-1:0]   LAST_IDX  = CMP_W'(TABLE_DEPTH - 1);
  localparam logic [RIDX_W-1:0]  LAST_RIDX = RIDX_W'(TABLE_DEPTH - 1);
  localparam logic [LCMP_W-1:0]  MAX_LAY_C = LCMP_W'(MAX_LAYER);
  localparam logic [LAYER_W-1:0] MAX_LAY_V = LAYER_W'(MAX_LAYER);
  localparam logic [CR_W-1:0]    FIFO_D_C  = CR_W'(FIFO_D);

  // ---------------------------------------------------------------------
  // Configuration registers; layer sizes clamp into 1..MAX_LAYER on write
  // ---------------------------------------------------------------------
  logic [rfl_pkg::METRIC_W-1:0] metric_q;
  logic                         enable_q;
  logic [LAYER_W-1:0]           layer_w_q;
  logic [LAYER_W-1:0]           layer_h_q;
  logic [LAYER_W-1:0]           layer_clamped;

  always_comb begin
    if (cfg_data_i == '0) begin
      layer_clamped = LAYER_W'(1);
    end else if ({{(LCMP_W - LAYER_W){1'b0}}, cfg_data_i} > MAX_LAY_C) begin
      layer_clamped = MAX_LAY_V;
    end else begin
      layer_clamped = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q  <= rfl_pkg::METRIC_R;
      enable_q  <= 1'b1;
      layer_w_q <= rfl_pkg::LAYER_RESET;
      layer_h_q <= rfl_pkg::LAYER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rfl_pkg::CFG_METRIC: metric_q  <= cfg_data_i[rfl_pkg::METRIC_W-1:0];
        rfl_pkg::CFG_ENABLE: enable_q  <= cfg_data_i[0];
        rfl_pkg::CFG_WIDTH:  layer_w_q <= layer_clamped;
        rfl_pkg::CFG_HEIGHT: layer_h_q <= layer_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input accept and credit count: items in flight plus queued results
  // ---------------------------------------------------------------------
  logic            in_acc;
  logic            out_pop;
  logic [CR_W-1:0] credit_q, credit_d;

  assign s_axis_tready_o = credit_q < FIFO_D_C;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_pop         = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    credit_d = credit_q;
    if (in_acc && !out_pop) begin
      credit_d = credit_q + CR_W'(1);
    end else if (out_pop && !in_acc) begin
      credit_d = credit_q - CR_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: unpack, fold the centered doubled coordinate, saturate value
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0] coord_x, coord_y;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [TX_W-1:0]           tx_d, ty_d;
  logic [WEIGHT_W-1:0]       evalue_raw;
  rfl_pkg::side_t            side1_d;

  assign coord_x    = s_axis_tdata_i[12:0];
  assign coord_y    = s_axis_tdata_i[25:13];
  assign evalue_raw = s_axis_tdata_i[64:36];

  always_comb begin
    dx = (DIFF_W'(coord_x) <<< 1) - $signed({{(DIFF_W - LAYER_W){1'b0}}, layer_w_q})
         + DIFF_W'(1);
    dy = (DIFF_W'(coord_y) <<< 1) - $signed({{(DIFF_W - LAYER_W){1'b0}}, layer_h_q})
         + DIFF_W'(1);
    tx_d = dx[DIFF_W-1] ? TX_W'(-dx) : dx[TX_W-1:0];
    ty_d = dy[DIFF_W-1] ? TX_W'(-dy) : dy[TX_W-1:0];

    side1_d          = '0;
    side1_d.op       = s_axis_tuser_i;
    side1_d.eidx     = s_axis_tdata_i[35:26];
    side1_d.evalue   = (evalue_raw > rfl_pkg::UNITY_WEIGHT) ? rfl_pkg::UNITY_WEIGHT
                                                            : evalue_raw;
  end

  logic           v1_q;
  logic [TX_W-1:0] tx1_q, ty1_q;
  rfl_pkg::side_t side1_q;

  // ---------------------------------------------------------------------
  // Stage 2: squares, max, and the R and S indexes
  // ---------------------------------------------------------------------
  logic [TX_W-1:0]   mx;
  logic [TX_W+1:0]   r_sum;
  logic [SQ_W-1:0]   sqx_d, sqy_d;
  rfl_pkg::side_t    side2_d;

  always_comb begin
    mx    = (tx1_q > ty1_q) ? tx1_q : ty1_q;
    r_sum = {2'b00, tx1_q} + {2'b00, ty1_q} + {2'b00, mx} + (TX_W + 2)'(1);
    sqx_d = SQ_W'(tx1_q) * SQ_W'(tx1_q);
    sqy_d = SQ_W'(ty1_q) * SQ_W'(ty1_q);
    side2_d = side1_q;
    case (metric_q)
      rfl_pkg::METRIC_R: begin
        side2_d.use_sqrt = 1'b0;
        side2_d.idx_rs   = r_sum[TX_W+1:2];
      end
      rfl_pkg::METRIC_S: begin
        // (2*max + 1) >> 2 is max >> 1
        side2_d.use_sqrt = 1'b0;
        side2_d.idx_rs   = IDX_W'(mx[TX_W-1:1]);
      end
      default: begin
        // Euclidean, also for the unused code
        side2_d.use_sqrt = 1'b1;
        side2_d.idx_rs   = '0;
      end
    endcase
  end

  logic            v2_q;
  logic [SQ_W-1:0] sqx2_q, sqy2_q;
  rfl_pkg::side_t  side2_q;

  // ---------------------------------------------------------------------
  // Stage 3: radicand 4 * (tx^2 + ty^2)
  // ---------------------------------------------------------------------
  logic [SQ_W:0]      sq_sum;
  logic [RAD_W-1:0]   rad_d;

  assign sq_sum = {1'b0, sqx2_q} + {1'b0, sqy2_q};
  assign rad_d  = RAD_W'(sq_sum) << 2;

  logic             v3_q;
  logic [RAD_W-1:0] rad3_q;
  rfl_pkg::side_t   side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      credit_q <= credit_d;
      v1_q     <= in_acc;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tx1_q   <= tx_d;
    ty1_q   <= ty_d;
    side1_q <= side1_d;
    sqx2_q  <= sqx_d;
    sqy2_q  <= sqy_d;
    side2_q <= side2_d;
    rad3_q  <= rad_d;
    side3_q <= side2_q;
  end

  // ---------------------------------------------------------------------
  // Square root chain: cell k settles root bit ROOT_W-1-k
  // ---------------------------------------------------------------------
  logic                valid_c [ROOT_W+1];
  logic [RAD_W-1:0]    rem_c   [ROOT_W+1];
  logic [ROOT_W-1:0]   root_c  [ROOT_W+1];
  rfl_pkg::side_t      side_c  [ROOT_W+1];

  assign valid_c[0] = v3_q;
  assign rem_c[0]   = rad3_q;
  assign root_c[0]  = '0;
  assign side_c[0]  = side3_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    rfl_cell #(
      .BIT (ROOT_W - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .rem_i   (rem_c[k]),
      .root_i  (root_c[k]),
      .side_i  (side_c[k]),
      .valid_o (valid_c[k+1]),
      .rem_o   (rem_c[k+1]),
      .root_o  (root_c[k+1]),
      .side_o  (side_c[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Index stage: pick the metric, clamp, drive the table ports
  // ---------------------------------------------------------------------
  rfl_pkg::side_t      side_e;
  logic [ROOT_W:0]     root_p2;
  logic [IDX_W-1:0]    sel_idx;
  logic [CMP_W-1:0]    idx_ext, idx_clamp, eidx_ext;
  logic                idx_clip, in_table, ram_we;
  logic [WEIGHT_W-1:0] a_weight_d;
  logic [RIDX_W-1:0]   a_ridx_d;
  logic                a_clip_d, a_use_ram_d;

  always_comb begin
    side_e    = side_c[ROOT_W];
    root_p2   = {1'b0, root_c[ROOT_W]} + (ROOT_W + 1)'(2);
    sel_idx   = side_e.use_sqrt ? root_p2[IDX_W+1:2] : side_e.idx_rs;
    idx_ext   = CMP_W'(sel_idx);
    idx_clip  = idx_ext >= DEPTH_C;
    idx_clamp = idx_clip ? LAST_IDX : idx_ext;
    eidx_ext  = CMP_W'(side_e.eidx);
    in_table  = eidx_ext < DEPTH_C;
    ram_we    = valid_c[ROOT_W] && (side_e.op == rfl_pkg::OP_WRITE) && in_table;

    a_use_ram_d = 1'b0;
    if (side_e.op == rfl_pkg::OP_WRITE) begin
      a_weight_d = side_e.evalue;
      a_ridx_d   = side_e.eidx;
      a_clip_d   = !in_table;
    end else if (!enable_q) begin
      a_weight_d = rfl_pkg::UNITY_WEIGHT;
      a_ridx_d   = '0;
      a_clip_d   = 1'b0;
    end else begin
      a_weight_d  = '0;
      a_ridx_d    = idx_clamp[RIDX_W-1:0];
      a_clip_d    = idx_clip;
      a_use_ram_d = 1'b1;
    end
  end

  logic [WEIGHT_W-1:0] ram_rdata;

  rfl_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (eidx_ext[ADDR_W-1:0]),
    .wdata_i (side_e.evalue),
    .raddr_i (idx_clamp[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  logic                a_valid_q;
  logic [WEIGHT_W-1:0] a_weight_q;
  logic [RIDX_W-1:0]   a_ridx_q;
  logic                a_clip_q, a_use_ram_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_c[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    a_weight_q  <= a_weight_d;
    a_ridx_q    <= a_ridx_d;
    a_clip_q    <= a_clip_d;
    a_use_ram_q <= a_use_ram_d;
  end

  // ---------------------------------------------------------------------
  // Result queue: push as the table data lands, pop on the output handshake
  // ---------------------------------------------------------------------
  logic [RES_W-1:0] res_d;

  assign res_d = {a_clip_q, a_ridx_q, a_use_ram_q ? ram_rdata : a_weight_q};

  rfl_fifo #(
    .WIDTH (RES_W),
    .DEPTH (FIFO_D)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (a_valid_q),
    .data_i  (res_d),
    .pop_i   (out_pop),
    .valid_o (m_axis_tvalid_o),
    .data_o  (m_axis_tdata_o)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic clip_lookup;

  assign clip_lookup = a_valid_q && a_use_ram_q && a_clip_q;

  `RFL_ASSERT_ALWAYS(a_credit_bound, credit_q <= FIFO_D_C, "credit count above queue depth")
  `RFL_ASSERT_IMPL(a_out_has_credit, m_axis_tvalid_o, credit_q != '0, "result without credit")
  `RFL_ASSERT_NEXT(a_accept_enters, in_acc, v1_q, "accepted item missing from first stage")
  `RFL_ASSERT_IMPL(a_clip_last, clip_lookup, a_ridx_q == LAST_RIDX, "clip not on last entry")

endmodule

`default_nettype wire

/* hdl/rfl_ram.sv */
// ----------------------------------------------------------------------------
// rfl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hdl/rfl_cell.sv */
// ----------------------------------------------------------------------------
// rfl_cell
// One cell of the square root chain: settle one root bit, hand on.
// ----------------------------------------------------------------------------
`default_nettype none

module rfl_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic [rfl_pkg::RAD_W-1:0]  rem_i,
  input  wire logic [rfl_pkg::ROOT_W-1:0] root_i,
  input  wire rfl_pkg::side_t             side_i,
  output logic                            valid_o,
  output logic      [rfl_pkg::RAD_W-1:0]  rem_o,
  output logic      [rfl_pkg::ROOT_W-1:0] root_o,
  output rfl_pkg::side_t                  side_o
);

  localparam int unsigned RAD_W   = rfl_pkg::RAD_W;
  localparam int unsigned ROOT_W  = rfl_pkg::ROOT_W;
  localparam int unsigned TRIAL_W = RAD_W + 1;

  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W-1:0] rem_ext;
  logic [TRIAL_W-1:0] diff;
  logic               fit;
  logic [RAD_W-1:0]   rem_d;
  logic [ROOT_W-1:0]  root_d;

  // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 4^BIT
  always_comb begin
    trial   = (TRIAL_W'(root_i) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
    rem_ext = {1'b0, rem_i};
    fit     = rem_ext >= trial;
    diff    = rem_ext - trial;
    rem_d   = fit ? diff[RAD_W-1:0] : rem_i;
    root_d  = fit ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o  <= rem_d;
    root_o <= root_d;
    side_o <= side_i;
  end

endmodule

`default_nettype wire

/* hdl/rfl_fifo.sv */
// ----------------------------------------------------------------------------
// rfl_fifo
// Result queue between the fixed-latency pipeline and the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module rfl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

/* bench/falloff_checker.sv */
// ----------------------------------------------------------------------------
// Falloff lookup checker
// Shared falloff arithmetic, plus a monitor that tracks the register writes
// and both item streams, predicts every result in order and compares it.
// ----------------------------------------------------------------------------

package falloff_math_pkg;
  import rfl_pkg::*;

  // Metric code with no metric of its own; the unit falls back to D.
  localparam logic [METRIC_W-1:0] METRIC_UNUSED = 2'd3;

  typedef struct packed {
    logic                clip;
    logic [RIDX_W-1:0]   radius_index;
    logic [WEIGHT_W-1:0] weight;
  } falloff_result_t;

  typedef struct packed {
    logic              clip;
    logic [RIDX_W-1:0] idx;
  } radius_t;

  // Zero reads as one cell, anything above the maximum as the maximum.
  function automatic logic [LAYER_W-1:0] fold_layer(logic [LAYER_W-1:0] raw);
    if (raw == '0) return LAYER_W'(1);
    if (raw > MAX_LAYER) return LAYER_W'(MAX_LAYER);
    return raw;
  endfunction

  // Doubled distance from the layer center along one axis.
  function automatic longint unsigned fold_coord(logic signed [COORD_W-1:0] c,
                                                 logic [LAYER_W-1:0] size);
    longint d;
    d = 2 * longint'(c) - longint'(size) + 1;
    return (d < 0) ? -d : d;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Table index for a coordinate under the given metric and layer size.
  function automatic radius_t falloff_radius(logic [METRIC_W-1:0] metric,
                                             logic [LAYER_W-1:0] w_raw,
                                             logic [LAYER_W-1:0] h_raw,
                                             logic [COORD_W-1:0] x,
                                             logic [COORD_W-1:0] y);
    longint unsigned tx, ty, mx, idx;
    radius_t r;
    tx = fold_coord(x, fold_layer(w_raw));
    ty = fold_coord(y, fold_layer(h_raw));
    mx = (tx > ty) ? tx : ty;
    case (metric)
      METRIC_R: idx = (tx + ty + mx + 1) >> 2;
      METRIC_S: idx = (mx + mx + 1) >> 2;
      default:  idx = (floor_root((tx * tx + ty * ty) << 2) + 2) >> 2;
    endcase
    r.clip = (idx >= TABLE_DEPTH);
    if (r.clip) idx = 64'(TABLE_DEPTH - 1);
    r.idx = idx[RIDX_W-1:0];
    return r;
  endfunction
endpackage

module falloff_checker
  import rfl_pkg::*;
  import falloff_math_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LAYER_W-1:0]   cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [71:0]          s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [39:0]          m_tdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   clipped_o
);
  logic [METRIC_W-1:0] metric_q;
  logic                enable_q;
  logic [LAYER_W-1:0]  width_q;
  logic [LAYER_W-1:0]  height_q;
  logic [WEIGHT_W-1:0] weight_table [TABLE_DEPTH];
  falloff_result_t     pending_weights [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    clipped_o    = 0;
  end

  always @(posedge clk_i) begin : watch
    falloff_result_t     want, got;
    radius_t             r;
    logic [WEIGHT_W-1:0] w;
    logic [EIDX_W-1:0]   eidx;
    if (!rst_ni) begin
      metric_q = METRIC_R;
      enable_q = 1'b1;
      width_q  = LAYER_RESET;
      height_q = LAYER_RESET;
      pending_weights.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_METRIC: metric_q = cfg_data_i[METRIC_W-1:0];
          CFG_ENABLE: enable_q = cfg_data_i[0];
          CFG_WIDTH:  width_q  = fold_layer(cfg_data_i);
          CFG_HEIGHT: height_q = fold_layer(cfg_data_i);
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == OP_WRITE) begin
          w    = s_tdata_i[64:36];
          eidx = s_tdata_i[35:26];
          if (w > UNITY_WEIGHT) w = UNITY_WEIGHT;
          want = '{clip: 1'b0, radius_index: eidx, weight: w};
          if (eidx < TABLE_DEPTH) weight_table[eidx] = w;
          else want.clip = 1'b1;
        end else if (!enable_q) begin
          want = '{clip: 1'b0, radius_index: '0, weight: UNITY_WEIGHT};
        end else begin
          r    = falloff_radius(metric_q, width_q, height_q,
                                s_tdata_i[12:0], s_tdata_i[25:13]);
          want = '{clip: r.clip, radius_index: r.idx, weight: weight_table[r.idx]};
        end
        pending_weights.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got = falloff_result_t'(m_tdata_i);
        if (pending_weights.size() == 0) begin
          fail_count_o++;
          $display({"%0t: unexpected result, expected none,",
                    " actual weight %0d index %0d clipped %0d"},
                   $time, got.weight, got.radius_index, got.clip);
        end else begin
          want = pending_weights.pop_front();
          checked_o++;
          if (got.clip) clipped_o++;
          if (got.weight !== want.weight || got.radius_index !== want.radius_index ||
              got.clip !== want.clip) begin
            fail_count_o++;
            $display({"%0t: result mismatch, expected weight %0d index %0d clipped %0d,",
                      " actual weight %0d index %0d clipped %0d"}, $time,
                     want.weight, want.radius_index, want.clip,
                     got.weight, got.radius_index, got.clip);
          end
        end
      end
    end
    pending_o = pending_weights.size();
  end
endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Radial falloff lookup unit testbench
// Drives directed and random lookup and table-write items through several
// register settings, with bursty input and a stalling output; the checker
// beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;
  import rfl_pkg::*;
  import falloff_math_pkg::*;

  localparam int unsigned RUN_LIMIT        = 300000;
  localparam int unsigned PHASES           = 12;
  localparam int unsigned ITEMS_PER_PHASE  = 102;
  localparam int unsigned HOLDOFF_PHASE    = 2;
  localparam int unsigned HOLDOFF_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES     = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LAYER_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [71:0]          in_data = '0;
  logic                 in_op = OP_LOOKUP;
  logic                 out_ready = 1'b0;
  wire                  in_ready;
  wire                  out_valid;
  wire  [39:0]          out_data;

  int fail_count, pending, checked, clipped;

  // Stimulus-side view of the registers, raw as written.
  logic [METRIC_W-1:0] cur_metric = METRIC_R;
  logic                cur_enable = 1'b1;
  logic [LAYER_W-1:0]  cur_width  = LAYER_RESET;
  logic [LAYER_W-1:0]  cur_height = LAYER_RESET;

  // Table entries that hold a defined value; lookups never touch the rest.
  bit entry_written [TABLE_DEPTH];

  int  burst_left = 0;
  bit  steady = 1'b0;        // no input gaps while set
  bit  holdoff_req = 1'b0;   // asks the receiver for one long stall
  int  n_items = 0, n_lookups = 0, n_writes = 0, n_settings = 0;
  int  cycles = 0;

  always #5 clk = ~clk;

  radial_falloff_lookup_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_op),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  falloff_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (in_valid),
    .s_tready_i   (in_ready),
    .s_tdata_i    (in_data),
    .s_tuser_i    (in_op),
    .m_tvalid_i   (out_valid),
    .m_tready_i   (out_ready),
    .m_tdata_i    (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .clipped_o    (clipped)
  );

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("** radial_falloff_lookup_unit: FAILED **");
      $finish;
    end
  end

  // Receiver: switch stall pattern when the current one runs out; on request,
  // hold off for a long stretch so the unit fills and backs up its input.
  initial begin : receiver
    int mode, mode_left, hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = HOLDOFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ~out_ready;
          2:       out_ready <= ($urandom_range(0, 9) < 7);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Write one register at the next falling edge and track it.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [LAYER_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_METRIC: cur_metric = data[METRIC_W-1:0];
      CFG_ENABLE: cur_enable = data[0];
      CFG_WIDTH:  cur_width  = data;
      CFG_HEIGHT: cur_height = data;
      default: ;
    endcase
  endtask

  // Load all four registers; call only with the unit empty.
  task automatic configure(logic [METRIC_W-1:0] metric, logic enable,
                           logic [LAYER_W-1:0] w, logic [LAYER_W-1:0] h);
    set_reg(CFG_METRIC, LAYER_W'(metric));
    set_reg(CFG_ENABLE, LAYER_W'(enable));
    set_reg(CFG_WIDTH, w);
    set_reg(CFG_HEIGHT, h);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Offer one item, with a random gap at the end of each burst; hold it
  // until the unit takes it.
  task automatic push_item(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [EIDX_W-1:0] eidx, logic [WEIGHT_W-1:0] evalue);
    int gap;
    if (burst_left == 0) begin
      if (steady) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(5, 20);
      else gap = $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_op    <= op;
    in_data  <= {7'd0, evalue, eidx, y, x};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  // Mix of in-range, saturating and boundary weights.
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    logic [WEIGHT_W-1:0] w;
    case ($urandom_range(0, 3))
      0: w = WEIGHT_W'($urandom);
      1: w = WEIGHT_W'($urandom_range(0, UNITY_WEIGHT));
      2: begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = UNITY_WEIGHT;
          2:       w = WEIGHT_W'(UNITY_WEIGHT + 1);
          default: w = '1;
        endcase
      end
      default: w = WEIGHT_W'($urandom_range(UNITY_WEIGHT - 4096, UNITY_WEIGHT + 4096));
    endcase
    return w;
  endfunction

  // Mostly on or just around the layer, sometimes anywhere in range.
  function automatic logic [COORD_W-1:0] rand_coord(logic [LAYER_W-1:0] raw);
    int c;
    if ($urandom_range(0, 2) == 0) c = $urandom;
    else c = int'($urandom_range(0, fold_layer(raw) + 15)) - 8;
    return c[COORD_W-1:0];
  endfunction

  task automatic write_entry(logic [EIDX_W-1:0] idx, logic [WEIGHT_W-1:0] value);
    push_item(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom), idx, value);
    entry_written[idx] = 1'b1;
    n_writes++;
  endtask

  // Load the entry a lookup will read first if it was never written.
  task automatic lookup(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    radius_t r;
    r = falloff_radius(cur_metric, cur_width, cur_height, x, y);
    if (cur_enable && !entry_written[r.idx]) write_entry(r.idx, rand_weight());
    push_item(OP_LOOKUP, x, y, EIDX_W'($urandom), WEIGHT_W'($urandom));
    n_lookups++;
  endtask

  function automatic logic [LAYER_W-1:0] pick_layer(int choice);
    case (choice)
      0:       return LAYER_W'(1);
      1:       return LAYER_W'(MAX_LAYER);
      2:       return '0;
      3:       return '1;
      4:       return LAYER_W'($urandom_range(1, MAX_LAYER));
      default: return LAYER_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [METRIC_W-1:0] metric;
    logic                enable;
    int                  phase_end;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: boundary weights, center and far corners at reset settings.
    write_entry(0, '0);
    write_entry(EIDX_W'(TABLE_DEPTH - 1), '1);
    write_entry(1, UNITY_WEIGHT);
    write_entry(2, WEIGHT_W'(UNITY_WEIGHT + 1));
    lookup(512, 512);
    lookup(-4096, -4096);
    lookup(4095, 4095);
    lookup(-4096, 4095);
    lookup(0, 0);
    drain();

    // Smallest layer, ring metric.
    configure(METRIC_S, 1'b1, 1, 1);
    lookup(0, 0);
    lookup(1, 0);
    drain();

    // Unused metric code, width of zero and height above the maximum.
    configure(METRIC_UNUSED, 1'b1, 0, '1);
    lookup(0, 512);
    lookup(4095, -4096);
    drain();

    // Falloff off: unity weight whatever the coordinate.
    configure(METRIC_D, 1'b0, LAYER_W'(MAX_LAYER), LAYER_W'(MAX_LAYER));
    lookup(-4096, 4095);
    lookup(17, 900);
    drain();

    // Random phases, one register setting each; early phases hit the extremes.
    for (int p = 0; p < PHASES; p++) begin
      metric = (p < 4) ? METRIC_W'(p) : METRIC_W'($urandom_range(0, 3));
      enable = !(p == 5 || $urandom_range(0, 5) == 0);
      configure(metric, enable, pick_layer(p < 6 ? p : $urandom_range(0, 5)),
                pick_layer($urandom_range(0, 5)));
      if (p == HOLDOFF_PHASE) begin
        holdoff_req = 1'b1;
        steady      = 1'b1;
      end
      // Count every item sent, table loads ahead of lookups included.
      phase_end = n_items + ITEMS_PER_PHASE;
      while (n_items < phase_end) begin
        if ($urandom_range(0, 9) < 3) write_entry(EIDX_W'($urandom), rand_weight());
        else lookup(rand_coord(cur_width), rand_coord(cur_height));
      end
      steady = 1'b0;
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run: %0d items (%0d lookups, %0d table writes) over %0d register settings",
             n_items, n_lookups, n_writes, n_settings);
    $display("run: %0d results checked, %0d clipped, %0d failures, one %0d-cycle hold-off",
             checked, clipped, fail_count, HOLDOFF_CYCLES);
    if (fail_count == 0) begin
      $display("** radial_falloff_lookup_unit: PASSED **");
    end else begin
      $display("** radial_falloff_lookup_unit: FAILED **");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+hdl
hdl/rfl_pkg.sv
hdl/rfl_ram.sv
hdl/rfl_cell.sv
hdl/rfl_fifo.sv
hdl/radial_falloff_lookup_unit.sv
bench/falloff_checker.sv
bench/testbench.sv
